@@ rtl/core/key_escape_drive_command_unit_assert.svh @@
// assertion macros for the key escape drive command unit
// used by files that check the block's own logic; needs clk_i and rst_ni in scope
`ifndef KEY_ESCAPE_DRIVE_COMMAND_UNIT_ASSERT_SVH
`define KEY_ESCAPE_DRIVE_COMMAND_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KEDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kedc assertion failed");
// next-cycle implication
`define KEDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kedc assertion failed");
`else
`define KEDC_ASSERT_IMP(lbl, ante, cons)
`define KEDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/kedc_pkg.sv @@
// shared types and constants of the key escape drive command unit
// no dependencies; imported by the front, queue, back and top modules
package kedc_pkg;

  // key codes
  localparam logic [7:0] KEY_ESC      = 8'h1b;
  localparam logic [7:0] KEY_BRACKET  = 8'h5b;
  localparam logic [7:0] KEY_UP       = 8'h41;
  localparam logic [7:0] KEY_DOWN     = 8'h42;
  localparam logic [7:0] KEY_RIGHT    = 8'h43;
  localparam logic [7:0] KEY_LEFT     = 8'h44;
  localparam logic [7:0] KEY_Q_LO     = 8'h71;
  localparam logic [7:0] KEY_Q_UP     = 8'h51;
  localparam logic [7:0] KEY_SPACE    = 8'h20;
  localparam logic [7:0] KEY_C_LO     = 8'h63;
  localparam logic [7:0] KEY_C_UP     = 8'h43;
  localparam logic [7:0] KEY_S_LO     = 8'h73;
  localparam logic [7:0] KEY_S_UP     = 8'h53;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_TIMEOUT = 3'd4;

  // configuration reset values
  localparam logic [14:0] FWD_SPEED_RST   = 15'd200;
  localparam logic [14:0] REV_SPEED_RST   = 15'd200;
  localparam logic [14:0] MAX_STEER_RST   = 15'd240;
  localparam logic [14:0] STEER_STEP_RST  = 15'd20;
  localparam logic [15:0] THR_TIMEOUT_RST = 16'd250;

  // command queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [14:0] fwd_speed;
    logic [14:0] rev_speed;
    logic [14:0] max_steer;
    logic [14:0] steer_step;
    logic [15:0] thr_timeout;
  } cfg_t;

  // escape parser phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2
  } phase_e;

  // decoded commands handed from front to back
  typedef enum logic [3:0] {
    CMD_TICK     = 4'd0,
    CMD_QUIT     = 4'd1,
    CMD_FWD      = 4'd2,
    CMD_REV      = 4'd3,
    CMD_STEER_DN = 4'd4,
    CMD_STEER_UP = 4'd5,
    CMD_HALT     = 4'd6,
    CMD_CENTER   = 4'd7,
    CMD_STOP     = 4'd8
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic [9:0]  elapsed;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

@@ rtl/core/kedc_front.sv @@
// front end: input handshake and escape parser, turns items into commands
// depends on kedc_pkg
module kedc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          func_i,
  input  logic [7:0]    byte_value_i,
  input  logic [9:0]    elapsed_ms_i,
  input  logic          queue_full_i,
  output logic          cmd_push_o,
  output kedc_pkg::cmd_t cmd_o
);
  import kedc_pkg::*;

  phase_e phase_q, phase_d;
  logic   in_fire;
  logic   has_cmd;
  cmd_e   op;

  // stall whenever the queue has no room
  assign in_stall_o = queue_full_i;
  assign in_fire    = in_valid_i && !queue_full_i;

  // phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else if (in_fire) begin
      phase_q <= phase_d;
    end
  end

  // next phase and command decode
  always_comb begin
    phase_d = phase_q;
    has_cmd = 1'b0;
    op      = CMD_TICK;
    if (func_i) begin
      has_cmd = 1'b1;
      op      = CMD_TICK;
    end else if (phase_q == PH_CSI) begin
      phase_d = PH_IDLE;
      unique case (byte_value_i)
        KEY_UP: begin
          has_cmd = 1'b1;
          op      = CMD_FWD;
        end
        KEY_DOWN: begin
          has_cmd = 1'b1;
          op      = CMD_REV;
        end
        KEY_RIGHT: begin
          has_cmd = 1'b1;
          op      = CMD_STEER_DN;
        end
        KEY_LEFT: begin
          has_cmd = 1'b1;
          op      = CMD_STEER_UP;
        end
        default: begin
          has_cmd = 1'b0;
        end
      endcase
    end else if (phase_q == PH_ESC && byte_value_i == KEY_BRACKET) begin
      phase_d = PH_CSI;
    end else begin
      // idle handling, also for a byte after a dropped escape
      phase_d = PH_IDLE;
      priority case (byte_value_i)
        KEY_ESC: begin
          phase_d = PH_ESC;
        end
        KEY_Q_LO, KEY_Q_UP: begin
          has_cmd = 1'b1;
          op      = CMD_QUIT;
        end
        KEY_SPACE: begin
          has_cmd = 1'b1;
          op      = CMD_HALT;
        end
        KEY_C_LO, KEY_C_UP: begin
          has_cmd = 1'b1;
          op      = CMD_CENTER;
        end
        KEY_S_LO, KEY_S_UP: begin
          has_cmd = 1'b1;
          op      = CMD_STOP;
        end
        default: begin
          has_cmd = 1'b0;
        end
      endcase
    end
  end

  assign cmd_push_o    = in_fire && has_cmd;
  assign cmd_o.op      = op;
  assign cmd_o.elapsed = elapsed_ms_i;

endmodule

@@ rtl/core/kedc_queue.sv @@
// short command queue between front and back
// depends on kedc_pkg
module kedc_queue #(
  parameter int unsigned Depth = kedc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  kedc_pkg::cmd_t        cmd_i,
  input  logic                  pop_i,
  output kedc_pkg::cmd_t        cmd_o,
  output kedc_pkg::queue_status_t status_o
);
  import kedc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o          = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == FullCnt);

endmodule

@@ rtl/core/kedc_back.sv @@
// back end: executes commands on the drive state and holds the result register
// depends on kedc_pkg
module kedc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kedc_pkg::cfg_t       cfg_i,
  input  logic                 queue_empty_i,
  input  kedc_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   speed_out_o,
  output logic signed [15:0]   steer_out_o,
  output logic                 quit_o
);
  import kedc_pkg::*;

  logic signed [15:0] speed_q, speed_d;
  logic signed [15:0] steer_q, steer_d;
  logic               armed_q, armed_d;
  logic [15:0]        since_q, since_d;
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_speed_q, out_speed_d;
  logic signed [15:0] out_steer_q, out_steer_d;
  logic               out_quit_q, out_quit_d;

  logic               slot_free;
  logic               pop;
  logic [16:0]        tick_sum;
  logic [15:0]        tick_sat;
  logic signed [16:0] steer_ext;
  logic signed [16:0] step_ext;
  logic signed [16:0] lim_ext;
  logic signed [16:0] steer_raw;
  logic signed [16:0] steer_clamped;

  // the result register frees up when empty or when its transfer completes
  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop       = !queue_empty_i && slot_free;
  assign cmd_pop_o = pop;

  // saturating tick counter
  assign tick_sum = {1'b0, since_q} + {7'b0, cmd_i.elapsed};
  assign tick_sat = tick_sum[16] ? 16'hffff : tick_sum[15:0];

  // steering step and clamp
  assign steer_ext = {steer_q[15], steer_q};
  assign step_ext  = $signed({2'b00, cfg_i.steer_step});
  assign lim_ext   = $signed({2'b00, cfg_i.max_steer});
  assign steer_raw = (cmd_i.op == CMD_STEER_DN) ? steer_ext - step_ext
                                                : steer_ext + step_ext;
  always_comb begin
    if (steer_raw > lim_ext) begin
      steer_clamped = lim_ext;
    end else if (steer_raw < -lim_ext) begin
      steer_clamped = -lim_ext;
    end else begin
      steer_clamped = steer_raw;
    end
  end

  // command execution
  always_comb begin
    speed_d     = speed_q;
    steer_d     = steer_q;
    armed_d     = armed_q;
    since_d     = since_q;
    out_valid_d = out_valid_q;
    out_speed_d = out_speed_q;
    out_steer_d = out_steer_q;
    out_quit_d  = out_quit_q;
    if (slot_free) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      unique case (cmd_i.op)
        CMD_TICK: begin
          since_d = tick_sat;
          if (armed_q && tick_sat > cfg_i.thr_timeout) begin
            speed_d = '0;
          end
          out_valid_d = 1'b1;
          out_speed_d = (armed_q && tick_sat > cfg_i.thr_timeout) ? 16'sd0 : speed_q;
          out_steer_d = steer_q;
          out_quit_d  = 1'b0;
        end
        CMD_QUIT: begin
          out_valid_d = 1'b1;
          out_speed_d = '0;
          out_steer_d = '0;
          out_quit_d  = 1'b1;
        end
        CMD_FWD: begin
          speed_d = $signed({1'b0, cfg_i.fwd_speed});
          since_d = '0;
          armed_d = 1'b1;
        end
        CMD_REV: begin
          speed_d = -$signed({1'b0, cfg_i.rev_speed});
          since_d = '0;
          armed_d = 1'b1;
        end
        CMD_STEER_DN, CMD_STEER_UP: begin
          steer_d = steer_clamped[15:0];
        end
        CMD_HALT: begin
          speed_d = '0;
          steer_d = '0;
          armed_d = 1'b0;
        end
        CMD_CENTER: begin
          steer_d = '0;
        end
        CMD_STOP: begin
          speed_d = '0;
          armed_d = 1'b0;
        end
        default: begin
          speed_d = speed_q;
        end
      endcase
    end
  end

  // drive state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= '0;
      steer_q     <= '0;
      armed_q     <= 1'b0;
      since_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      speed_q     <= speed_d;
      steer_q     <= steer_d;
      armed_q     <= armed_d;
      since_q     <= since_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_speed_q <= out_speed_d;
    out_steer_q <= out_steer_d;
    out_quit_q  <= out_quit_d;
  end

  assign out_valid_o = out_valid_q;
  assign speed_out_o = out_speed_q;
  assign steer_out_o = out_steer_q;
  assign quit_o      = out_quit_q;

endmodule

@@ rtl/core/key_escape_drive_command_unit.sv @@
// Keyboard escape-sequence drive command unit. Terminal bytes and publish
// ticks enter on one channel; arrow-key escape sequences, stop/center keys
// and the quit key steer a speed (mm/s) and steering (mrad) command, and each
// tick or quit key yields one result. While in_stall_o is low the unit takes
// one item per cycle: the front parser classifies an item in the cycle it is
// accepted and pushes a command into a small queue, and the back end executes
// one command per cycle into a registered result stage whenever that stage is
// free. Throughput is bounded only by the queue (in_stall_o rises when it is
// full) and by output stall; an item passes the queue and the result register.
// Configuration registers are written through cfg_valid_i/cfg_ready_o, which
// never stalls. Top level; depends on kedc_pkg, kedc_front, kedc_queue,
// kedc_back and key_escape_drive_command_unit_assert.svh
`include "key_escape_drive_command_unit_assert.svh"

module key_escape_drive_command_unit #(
  parameter int unsigned QueueDepth = kedc_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [7:0]                    byte_value_i,
  input  logic [9:0]                    elapsed_ms_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            speed_out_o,
  output logic signed [15:0]            steer_out_o,
  output logic                          quit_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kedc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import kedc_pkg::*;

  cfg_t          cfg_q;
  cmd_t          push_cmd;
  cmd_t          head_cmd;
  logic          cmd_push;
  logic          cmd_pop;
  queue_status_t q_status;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fwd_speed   <= FWD_SPEED_RST;
      cfg_q.rev_speed   <= REV_SPEED_RST;
      cfg_q.max_steer   <= MAX_STEER_RST;
      cfg_q.steer_step  <= STEER_STEP_RST;
      cfg_q.thr_timeout <= THR_TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FWD_SPEED:   cfg_q.fwd_speed   <= cfg_data_i[14:0];
        CFG_REV_SPEED:   cfg_q.rev_speed   <= cfg_data_i[14:0];
        CFG_MAX_STEER:   cfg_q.max_steer   <= cfg_data_i[14:0];
        CFG_STEER_STEP:  cfg_q.steer_step  <= cfg_data_i[14:0];
        CFG_THR_TIMEOUT: cfg_q.thr_timeout <= cfg_data_i;
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // parser front end
  kedc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .byte_value_i (byte_value_i),
    .elapsed_ms_i (elapsed_ms_i),
    .queue_full_i (q_status.full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (push_cmd)
  );

  // command queue
  kedc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (cmd_push),
    .cmd_i    (push_cmd),
    .pop_i    (cmd_pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  // execution back end
  kedc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .queue_empty_i (q_status.empty),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .speed_out_o   (speed_out_o),
    .steer_out_o   (steer_out_o),
    .quit_o        (quit_o)
  );

  // a tick transfer always becomes a queued command
  `KEDC_ASSERT_IMP(a_tick_pushed, in_valid_i && !in_stall_o && func_i, cmd_push)
  // the back end never pops an empty queue
  `KEDC_ASSERT_IMP(a_pop_nonempty, cmd_pop, !q_status.empty)
  // a quit result carries zero speed and steering
  `KEDC_ASSERT_IMP(a_quit_zero, out_valid_o && quit_o, speed_out_o == 16'sd0 && steer_out_o == 16'sd0)

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// self-checking bench for key_escape_drive_command_unit: escape parser, drive state and ticks
// depends on kedc_pkg and the unit's rtl; predicts every result and checks it in order

module testbench;
  import kedc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 203;

  // one terminal byte or publish tick
  typedef struct packed {
    logic       func;
    logic [7:0] key;
    logic [9:0] elapsed;
  } key_item_t;

  // one drive command result
  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] steer;
    logic               quit;
  } drive_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic [7:0] byte_value_i = '0;
  logic [9:0] elapsed_ms_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] speed_out_o;
  logic signed [15:0] steer_out_o;
  logic quit_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  // pending items, predicted commands, bookkeeping
  key_item_t  key_items[$];
  drive_cmd_t want_cmds[$];
  key_item_t  drv_item;
  drive_cmd_t got_cmd;
  drive_cmd_t want_cmd;
  bit         in_took = 1'b0;
  bit         no_gaps = 1'b0;
  int unsigned items_queued = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // predicted block state
  cfg_t               drive_cfg;
  phase_e             esc_phase;
  logic signed [15:0] drive_speed;
  logic signed [15:0] drive_steer;
  logic               throttle_armed;
  logic [15:0]        ms_since_throttle;

  key_escape_drive_command_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .byte_value_i (byte_value_i),
    .elapsed_ms_i (elapsed_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .speed_out_o  (speed_out_o),
    .steer_out_o  (steer_out_o),
    .quit_o       (quit_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // clamp a steering value to the configured magnitude
  function automatic logic signed [15:0] clamp_steer(input int v);
    int lim;
    lim = int'(drive_cfg.max_steer);
    if (v > lim) return 16'(lim);
    if (v < -lim) return 16'(-lim);
    return 16'(v);
  endfunction

  // advance the drive state by one accepted item and queue any result
  task automatic predict_drive(input logic fn, input logic [7:0] b, input logic [9:0] el);
    int sum;
    bit idle_key;
    drive_cmd_t r;
    idle_key = 1'b0;
    if (fn) begin
      sum = int'(ms_since_throttle) + int'(el);
      ms_since_throttle = (sum > 65535) ? 16'hffff : sum[15:0];
      if (throttle_armed && ms_since_throttle > drive_cfg.thr_timeout) drive_speed = '0;
      r.speed = drive_speed;
      r.steer = drive_steer;
      r.quit = 1'b0;
      want_cmds.push_back(r);
      return;
    end
    case (esc_phase)
      PH_ESC: begin
        if (b == KEY_BRACKET) begin
          esc_phase = PH_CSI;
        end else begin
          esc_phase = PH_IDLE;
          idle_key = 1'b1;
        end
      end
      PH_CSI: begin
        esc_phase = PH_IDLE;
        case (b)
          KEY_UP: begin
            drive_speed = $signed({1'b0, drive_cfg.fwd_speed});
            ms_since_throttle = '0;
            throttle_armed = 1'b1;
          end
          KEY_DOWN: begin
            drive_speed = -$signed({1'b0, drive_cfg.rev_speed});
            ms_since_throttle = '0;
            throttle_armed = 1'b1;
          end
          KEY_RIGHT: drive_steer = clamp_steer(int'(drive_steer) - int'(drive_cfg.steer_step));
          KEY_LEFT: drive_steer = clamp_steer(int'(drive_steer) + int'(drive_cfg.steer_step));
          default: ;
        endcase
      end
      default: begin
        esc_phase = PH_IDLE;
        idle_key = 1'b1;
      end
    endcase
    if (!idle_key) return;
    case (b)
      KEY_ESC: esc_phase = PH_ESC;
      KEY_Q_LO, KEY_Q_UP: begin
        r.speed = '0;
        r.steer = '0;
        r.quit = 1'b1;
        want_cmds.push_back(r);
      end
      KEY_SPACE: begin
        drive_speed = '0;
        drive_steer = '0;
        throttle_armed = 1'b0;
      end
      KEY_C_LO, KEY_C_UP: drive_steer = '0;
      KEY_S_LO, KEY_S_UP: begin
        drive_speed = '0;
        throttle_armed = 1'b0;
      end
      default: ;
    endcase
  endtask

  // stimulus builders
  task automatic queue_key(input logic [7:0] b);
    key_items.push_back('{func: 1'b0, key: b, elapsed: 10'($urandom_range(1023))});
    items_queued++;
  endtask

  task automatic queue_tick(input logic [9:0] el);
    key_items.push_back('{func: 1'b1, key: 8'($urandom_range(255)), elapsed: el});
    items_queued++;
  endtask

  task automatic queue_escape(input logic [7:0] code);
    queue_key(KEY_ESC);
    queue_key(KEY_BRACKET);
    queue_key(code);
  endtask

  // one random token: mostly well-formed sequences, some broken ones and noise
  task automatic queue_random_token();
    int pick;
    int sub;
    pick = $urandom_range(99);
    sub = $urandom_range(3);
    if (pick < 30) begin
      queue_escape(KEY_UP + 8'(sub));
    end else if (pick < 55) begin
      if (sub == 0) queue_tick(10'd1023);
      else if (sub == 1) queue_tick(10'($urandom_range(300)));
      else queue_tick(10'($urandom_range(1023)));
    end else if (pick < 67) begin
      case ($urandom_range(4))
        0: queue_key(KEY_SPACE);
        1: queue_key(KEY_C_LO);
        2: queue_key(KEY_C_UP);
        3: queue_key(KEY_S_LO);
        default: queue_key(KEY_S_UP);
      endcase
    end else if (pick < 72) begin
      queue_key(sub[0] ? KEY_Q_UP : KEY_Q_LO);
    end else if (pick < 80) begin
      queue_key(KEY_ESC);
      queue_key(8'($urandom_range(255)));
    end else if (pick < 86) begin
      queue_key(KEY_ESC);
      queue_key(KEY_BRACKET);
      queue_key(8'($urandom_range(255)));
    end else begin
      queue_key(8'($urandom_range(255)));
    end
  endtask

  // register write over the config channel, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FWD_SPEED: drive_cfg.fwd_speed = data[14:0];
      CFG_REV_SPEED: drive_cfg.rev_speed = data[14:0];
      CFG_MAX_STEER: drive_cfg.max_steer = data[14:0];
      CFG_STEER_STEP: drive_cfg.steer_step = data[14:0];
      CFG_THR_TIMEOUT: drive_cfg.thr_timeout = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every item is taken and every result is back, then let the pipe empty
  task automatic drain();
    while (key_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (want_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) predict_drive(func_i, byte_value_i, elapsed_ms_i);
  end

  // item driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (key_items.size() != 0 && (no_gaps || $urandom_range(99) >= 23)) begin
        drv_item = key_items.pop_front();
        in_valid_i <= 1'b1;
        func_i <= drv_item.func;
        byte_value_i <= drv_item.key;
        elapsed_ms_i <= drv_item.elapsed;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= !no_gaps && ($urandom_range(99) < 23);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_cmd = '{speed: speed_out_o, steer: steer_out_o, quit: quit_o};
      if (want_cmds.size() == 0) begin
        $display("%0t: unexpected result speed %0d steer %0d quit %0b",
                 $time, got_cmd.speed, got_cmd.steer, got_cmd.quit);
        errors++;
      end else begin
        want_cmd = want_cmds.pop_front();
        if (got_cmd.speed !== want_cmd.speed) begin
          $display("%0t: speed_out expected %0d actual %0d", $time, want_cmd.speed, got_cmd.speed);
          errors++;
        end
        if (got_cmd.steer !== want_cmd.steer) begin
          $display("%0t: steer_out expected %0d actual %0d", $time, want_cmd.steer, got_cmd.steer);
          errors++;
        end
        if (got_cmd.quit !== want_cmd.quit) begin
          $display("%0t: quit expected %0b actual %0b", $time, want_cmd.quit, got_cmd.quit);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    drive_cfg = '{fwd_speed: FWD_SPEED_RST, rev_speed: REV_SPEED_RST, max_steer: MAX_STEER_RST,
                  steer_step: STEER_STEP_RST, thr_timeout: THR_TIMEOUT_RST};
    esc_phase = PH_IDLE;
    drive_speed = '0;
    drive_steer = '0;
    throttle_armed = 1'b0;
    ms_since_throttle = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every command, broken and repeated escapes
    queue_tick(10'd0);
    queue_tick(10'd1023);
    queue_key(KEY_ESC);
    queue_escape(KEY_UP);
    queue_tick(10'd1);
    queue_escape(KEY_DOWN);
    queue_escape(KEY_RIGHT);
    queue_escape(KEY_LEFT);
    queue_key(KEY_ESC);
    queue_key(KEY_Q_LO);
    queue_key(KEY_Q_UP);
    queue_escape(KEY_ESC);
    queue_key(KEY_C_LO);
    queue_key(KEY_SPACE);
    queue_key(KEY_S_LO);
    queue_tick(10'd300);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        1: begin
          // top of every range, upper bit dropped on the 15-bit registers
          write_reg(CFG_FWD_SPEED, 16'hffff);
          write_reg(CFG_REV_SPEED, 16'hffff);
          write_reg(CFG_MAX_STEER, 16'hffff);
          write_reg(CFG_STEER_STEP, 16'hffff);
          write_reg(CFG_THR_TIMEOUT, 16'hffff);
        end
        2: begin
          write_reg(CFG_FWD_SPEED, 16'd0);
          write_reg(CFG_REV_SPEED, 16'd0);
          write_reg(CFG_MAX_STEER, 16'd0);
          write_reg(CFG_STEER_STEP, 16'd0);
          write_reg(CFG_THR_TIMEOUT, 16'd0);
        end
        3: begin
          // tight clamp pulls in earlier steering
          write_reg(CFG_FWD_SPEED, 16'($urandom_range(65535)));
          write_reg(CFG_REV_SPEED, 16'h7fff);
          write_reg(CFG_MAX_STEER, 16'd7);
          write_reg(CFG_STEER_STEP, 16'd3);
          write_reg(CFG_THR_TIMEOUT, 16'($urandom_range(2000)));
        end
        default: begin
          write_reg(CFG_FWD_SPEED, 16'($urandom_range(65535)));
          write_reg(CFG_REV_SPEED, 16'($urandom_range(65535)));
          write_reg(CFG_MAX_STEER, 16'($urandom_range(65535)));
          write_reg(CFG_STEER_STEP, 16'($urandom_range(65535)));
          write_reg(CFG_THR_TIMEOUT, 16'($urandom_range(3000)));
        end
      endcase
      no_gaps = (ph == 4);
      items_queued = 0;
      // long tick run saturates the millisecond counter
      if (ph == 1 || ph == 5) begin
        queue_escape(KEY_UP);
        repeat (70) queue_tick(10'd1023);
      end
      while (items_queued < PHASE_ITEMS) queue_random_token();
      drain();
    end
    no_gaps = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/kedc_pkg.sv
rtl/core/kedc_front.sv
rtl/core/kedc_queue.sv
rtl/core/kedc_back.sv
rtl/core/key_escape_drive_command_unit.sv
tb/sv/testbench.sv
